// ----- design/asos_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asos_pkg
// Shared widths, Q30 angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package asos_pkg;

  localparam int QB     = 30;   // internal fraction bits
  localparam int W      = 36;   // CORDIC datapath width
  localparam int IN_W   = 24;
  localparam int SEP_W  = 22;
  localparam int VEC_W  = 32;   // sine, cosine, vector component width
  localparam int SQ_W   = 62;   // square root operand width
  localparam int SQ_STEPS = 31; // result bits of the root
  localparam int NUM_LANES = 4;

  localparam int LANE_POLAR_A   = 0;
  localparam int LANE_AZIMUTH_A = 1;
  localparam int LANE_POLAR_B   = 2;
  localparam int LANE_AZIMUTH_B = 3;

  localparam logic signed [W-1:0] PI_Q      = 36'sd3373259426;
  localparam logic signed [W-1:0] HALF_PI_Q = 36'sd1686629713;
  localparam logic signed [W-1:0] TWO_PI_Q  = 36'sd6746518852;
  localparam logic signed [W-1:0] GAIN_Q    = 36'sd652032874;
  localparam logic signed [W-1:0] ONE_Q     = 36'sd1073741824;

  localparam logic signed [W-1:0] ATAN_HEAD [10] = '{
    36'sd843314856, 36'sd497837829, 36'sd263043836, 36'sd133525158, 36'sd67021686,
    36'sd33543515, 36'sd16775850, 36'sd8388437, 36'sd4194282, 36'sd2097149
  };

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [W-1:0] atan_q(input int i);
    logic signed [W-1:0] r;
    if (i < 10) begin
      r = ATAN_HEAD[i];
    end else if (i <= QB) begin
      r = (W'(1) <<< (QB - i)) - W'(1);
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

// ----- design/asos_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asos_in_if
// Input channel: one pair of sky directions per item.
// ----------------------------------------------------------------------------
interface asos_in_if;
  import asos_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] polar_a;
  logic signed [IN_W-1:0] azimuth_a;
  logic signed [IN_W-1:0] polar_b;
  logic signed [IN_W-1:0] azimuth_b;

  modport source (output valid, polar_a, azimuth_a, polar_b, azimuth_b, input ready);
  modport sink   (input valid, polar_a, azimuth_a, polar_b, azimuth_b, output ready);
endinterface

// ----- design/asos_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asos_out_if
// Output channel: angular separation and clamp flag per item.
// ----------------------------------------------------------------------------
interface asos_out_if;
  import asos_pkg::*;

  logic              valid;
  logic              ready;
  logic [SEP_W-1:0]  separation;
  logic              clamped;

  modport source (output valid, separation, clamped, input ready);
  modport sink   (input valid, separation, clamped, output ready);
endinterface

// ----- design/asos_reduce.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asos_reduce
// Four-stage range reduction of one angle to [-pi/2, pi/2] in Q30.
// ----------------------------------------------------------------------------
module asos_reduce #(
  parameter int ANGLE_FRAC_BITS = 20
) (
  input  logic                              clk_i,
  input  logic [3:0]                        en_i,
  input  logic signed [asos_pkg::IN_W-1:0]  ang_i,
  output logic signed [asos_pkg::W-1:0]     z_o,
  output logic                              neg_o
);
  import asos_pkg::*;

  localparam int PRE   = QB - ANGLE_FRAC_BITS;
  localparam int RSH   = 40;
  localparam int Q_W   = 12;
  localparam int R_W   = 44;
  localparam int RCP_W = 27;
  localparam longint unsigned RECIP =
    ((64'd1 << (PRE + RSH)) + 64'(TWO_PI_Q) / 2) / 64'(TWO_PI_Q);
  localparam logic [RCP_W-1:0] RECIP_C = RCP_W'(RECIP);

  logic signed [IN_W+RCP_W:0] prod;
  logic signed [Q_W-1:0]      q_d, q_q;
  logic signed [IN_W-1:0]     v_q;
  logic signed [R_W-1:0]      r_full, qm;
  logic signed [W-1:0]        rem_d, rem_q, cor_d, cor_q, z_d;
  logic                       neg_d;

  // quotient estimate by reciprocal, off by at most one
  always_comb begin
    prod = ang_i * $signed({1'b0, RECIP_C});
    q_d  = Q_W'(prod >>> RSH);
  end

  always_comb begin
    r_full = R_W'(v_q) <<< PRE;
    qm     = R_W'(q_q) * R_W'(TWO_PI_Q);
    rem_d  = W'(r_full - qm);
  end

  always_comb begin
    if (rem_q < 0) begin
      cor_d = rem_q + TWO_PI_Q;
    end else if (rem_q >= TWO_PI_Q) begin
      cor_d = rem_q - TWO_PI_Q;
    end else begin
      cor_d = rem_q;
    end
  end

  // fold [0, 2pi) into [-pi/2, pi/2], sign flip where shifted by pi
  always_comb begin
    if (cor_q <= HALF_PI_Q) begin
      z_d   = cor_q;
      neg_d = 1'b0;
    end else if (cor_q < TWO_PI_Q - HALF_PI_Q) begin
      z_d   = cor_q - PI_Q;
      neg_d = 1'b1;
    end else begin
      z_d   = cor_q - TWO_PI_Q;
      neg_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      q_q <= q_d;
      v_q <= ang_i;
    end
    if (en_i[1]) begin
      rem_q <= rem_d;
    end
    if (en_i[2]) begin
      cor_q <= cor_d;
    end
    if (en_i[3]) begin
      z_o   <= z_d;
      neg_o <= neg_d;
    end
  end
endmodule

// ----- design/asos_cordic_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asos_cordic_cell
// One CORDIC iteration, rotation or vectoring mode, with a carried tag.
// ----------------------------------------------------------------------------
module asos_cordic_cell #(
  parameter int STEP      = 0,
  parameter bit VECTORING = 1'b0,
  parameter int TAG_W     = 1
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [asos_pkg::W-1:0] x_i,
  input  logic signed [asos_pkg::W-1:0] y_i,
  input  logic signed [asos_pkg::W-1:0] z_i,
  input  logic [TAG_W-1:0]              tag_i,
  output logic signed [asos_pkg::W-1:0] x_o,
  output logic signed [asos_pkg::W-1:0] y_o,
  output logic signed [asos_pkg::W-1:0] z_o,
  output logic [TAG_W-1:0]              tag_o
);
  import asos_pkg::*;

  localparam logic signed [W-1:0] ATAN = atan_q(STEP);

  logic signed [W-1:0] dx, dy, x_d, y_d, z_d;
  logic                up;

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    up = VECTORING ? !(y_i > 0) : (z_i >= 0);
    if (up) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o   <= x_d;
      y_o   <= y_d;
      z_o   <= z_d;
      tag_o <= tag_i;
    end
  end
endmodule

// ----- design/asos_dot.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asos_dot
// Five stages: sign fix, vector components, dot product with clamp, 1 - d*d.
// ----------------------------------------------------------------------------
module asos_dot (
  input  logic                              clk_i,
  input  logic [4:0]                        en_i,
  input  logic signed [asos_pkg::W-1:0]     x_i [asos_pkg::NUM_LANES],
  input  logic signed [asos_pkg::W-1:0]     y_i [asos_pkg::NUM_LANES],
  input  logic [asos_pkg::NUM_LANES-1:0]    neg_i,
  output logic signed [asos_pkg::VEC_W-1:0] d_o,
  output logic [asos_pkg::SQ_W-1:0]         sq_o,
  output logic                              clamp_o
);
  import asos_pkg::*;

  localparam int P_W = 2 * VEC_W;

  logic signed [VEC_W-1:0] s_q [NUM_LANES];
  logic signed [VEC_W-1:0] c_q [NUM_LANES];
  logic signed [VEC_W-1:0] xa_q, ya_q, xb_q, yb_q, d_d, d_q;
  logic signed [P_W-1:0]   ctab_q, ctab2_q, pxx_q, pyy_q;
  logic signed [P_W-1:0]   pxa, pya, pxb, pyb, sum, dsq;
  logic signed [P_W-31:0]  dwide;
  logic                    clamp_d, clamp_q;

  always_comb begin
    pxa = s_q[LANE_POLAR_A] * c_q[LANE_AZIMUTH_A];
    pya = s_q[LANE_POLAR_A] * s_q[LANE_AZIMUTH_A];
    pxb = s_q[LANE_POLAR_B] * c_q[LANE_AZIMUTH_B];
    pyb = s_q[LANE_POLAR_B] * s_q[LANE_AZIMUTH_B];
  end

  always_comb begin
    sum   = pxx_q + pyy_q + ctab2_q;
    dwide = sum[P_W-1:QB];
    if (dwide > (P_W-30)'(ONE_Q)) begin
      d_d     = VEC_W'(ONE_Q);
      clamp_d = 1'b1;
    end else if (dwide < -(P_W-30)'(ONE_Q)) begin
      d_d     = -VEC_W'(ONE_Q);
      clamp_d = 1'b1;
    end else begin
      d_d     = VEC_W'(dwide);
      clamp_d = 1'b0;
    end
  end

  assign dsq = d_q * d_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        s_q[l] <= VEC_W'(neg_i[l] ? -y_i[l] : y_i[l]);
        c_q[l] <= VEC_W'(neg_i[l] ? -x_i[l] : x_i[l]);
      end
    end
    if (en_i[1]) begin
      xa_q   <= pxa[P_W-3:QB];
      ya_q   <= pya[P_W-3:QB];
      xb_q   <= pxb[P_W-3:QB];
      yb_q   <= pyb[P_W-3:QB];
      ctab_q <= c_q[LANE_POLAR_A] * c_q[LANE_POLAR_B];
    end
    if (en_i[2]) begin
      pxx_q   <= xa_q * xb_q;
      pyy_q   <= ya_q * yb_q;
      ctab2_q <= ctab_q;
    end
    if (en_i[3]) begin
      d_q     <= d_d;
      clamp_q <= clamp_d;
    end
    if (en_i[4]) begin
      d_o     <= d_q;
      clamp_o <= clamp_q;
      sq_o    <= SQ_W'((P_W'(1) <<< (2 * QB)) - dsq);
    end
  end
endmodule

// ----- design/asos_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asos_sqrt_cell
// One digit of the integer square root, carrying the dot product along.
// ----------------------------------------------------------------------------
module asos_sqrt_cell #(
  parameter int K = 0
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [asos_pkg::SQ_W-1:0]         rem_i,
  input  logic [asos_pkg::SQ_W-1:0]         res_i,
  input  logic signed [asos_pkg::VEC_W-1:0] d_i,
  input  logic                              clamp_i,
  output logic [asos_pkg::SQ_W-1:0]         rem_o,
  output logic [asos_pkg::SQ_W-1:0]         res_o,
  output logic signed [asos_pkg::VEC_W-1:0] d_o,
  output logic                              clamp_o
);
  import asos_pkg::*;

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

  logic [SQ_W-1:0] t, rem_d, res_d;

  always_comb begin
    t = res_i + BIT;
    if (rem_i >= t) begin
      rem_d = rem_i - t;
      res_d = (res_i >> 1) + BIT;
    end else begin
      rem_d = rem_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o   <= rem_d;
      res_o   <= res_d;
      d_o     <= d_i;
      clamp_o <= clamp_i;
    end
  end
endmodule

// ----- design/angular_separation_on_sphere_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angular_separation_on_sphere_core
// Great-circle angle between two directions given as polar angle and azimuth.
// ----------------------------------------------------------------------------
// Takes one pair of directions per clock while the output is not stalled, and
// returns one separation per item, in order. The pipeline is range reduction,
// a rotation CORDIC chain of CORDIC_STEPS cells for the four sines and cosines,
// the products and clamp, a 31-cell square root chain, a setup register and a
// vectoring CORDIC chain for the arccosine, then the rounding register. Every
// stage holds its item while the next one is full, so empty stages keep filling
// while a result waits.
module angular_separation_on_sphere_core #(
  parameter int ANGLE_FRAC_BITS = 20,
  parameter int CORDIC_STEPS    = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  asos_in_if.sink   req_i,
  asos_out_if.source rsp_o
);
  import asos_pkg::*;

  localparam int S       = CORDIC_STEPS;
  localparam int ROT0    = 4;
  localparam int DOT0    = ROT0 + S;
  localparam int SQ0     = DOT0 + 5;
  localparam int PREP    = SQ0 + SQ_STEPS;
  localparam int VEC0    = PREP + 1;
  localparam int FIN     = VEC0 + S;
  localparam int N       = FIN + 1;
  localparam int SH      = QB - ANGLE_FRAC_BITS;
  localparam int RND_SH  = (SH > 0) ? SH - 1 : 0;
  localparam logic [W:0] RND = (SH > 0) ? ((W + 1)'(1) << RND_SH) : '0;
  localparam logic [W:0] SEP_MAX = (W + 1)'({SEP_W{1'b1}});

  logic [N-1:0] vld_q, vld_d;
  logic [N:0]   en;

  // a stage loads when it is empty or its item moves on
  assign en[N] = rsp_o.ready;
  for (genvar k = 0; k < N; k++) begin : g_en
    assign en[k] = ~vld_q[k] | en[k + 1];
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (en[k]) begin
        vld_d[k] = (k == 0) ? req_i.valid : vld_q[(k == 0) ? 0 : k - 1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign req_i.ready = en[0];

  // sine and cosine lanes
  logic signed [IN_W-1:0] ang [NUM_LANES];
  logic signed [W-1:0]    rx [NUM_LANES][S+1];
  logic signed [W-1:0]    ry [NUM_LANES][S+1];
  logic signed [W-1:0]    rz [NUM_LANES][S+1];
  logic                   rt [NUM_LANES][S+1];
  logic signed [W-1:0]    cs_x [NUM_LANES];
  logic signed [W-1:0]    cs_y [NUM_LANES];
  logic [NUM_LANES-1:0]   cs_neg;

  assign ang[LANE_POLAR_A]   = req_i.polar_a;
  assign ang[LANE_AZIMUTH_A] = req_i.azimuth_a;
  assign ang[LANE_POLAR_B]   = req_i.polar_b;
  assign ang[LANE_AZIMUTH_B] = req_i.azimuth_b;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    asos_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_reduce (
      .clk_i (clk_i),
      .en_i  (en[3:0]),
      .ang_i (ang[l]),
      .z_o   (rz[l][0]),
      .neg_o (rt[l][0])
    );
    assign rx[l][0] = GAIN_Q;
    assign ry[l][0] = '0;

    for (genvar i = 0; i < S; i++) begin : g_rot
      asos_cordic_cell #(.STEP(i), .VECTORING(1'b0), .TAG_W(1)) u_cell (
        .clk_i (clk_i),
        .en_i  (en[ROT0 + i]),
        .x_i   (rx[l][i]),
        .y_i   (ry[l][i]),
        .z_i   (rz[l][i]),
        .tag_i (rt[l][i]),
        .x_o   (rx[l][i+1]),
        .y_o   (ry[l][i+1]),
        .z_o   (rz[l][i+1]),
        .tag_o (rt[l][i+1])
      );
    end

    assign cs_x[l]   = rx[l][S];
    assign cs_y[l]   = ry[l][S];
    assign cs_neg[l] = rt[l][S];
  end

  // dot product
  logic signed [VEC_W-1:0] sd [SQ_STEPS+1];
  logic [SQ_W-1:0]         srem [SQ_STEPS+1];
  logic [SQ_W-1:0]         sres [SQ_STEPS+1];
  logic                    sclp [SQ_STEPS+1];

  asos_dot u_dot (
    .clk_i   (clk_i),
    .en_i    (en[SQ0-1:DOT0]),
    .x_i     (cs_x),
    .y_i     (cs_y),
    .neg_i   (cs_neg),
    .d_o     (sd[0]),
    .sq_o    (srem[0]),
    .clamp_o (sclp[0])
  );
  assign sres[0] = '0;

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    asos_sqrt_cell #(.K(SQ_STEPS - 1 - j)) u_cell (
      .clk_i   (clk_i),
      .en_i    (en[SQ0 + j]),
      .rem_i   (srem[j]),
      .res_i   (sres[j]),
      .d_i     (sd[j]),
      .clamp_i (sclp[j]),
      .rem_o   (srem[j+1]),
      .res_o   (sres[j+1]),
      .d_o     (sd[j+1]),
      .clamp_o (sclp[j+1])
    );
  end

  // arccosine setup: left half plane is rotated by -90 degrees first
  logic signed [W-1:0] vx [S+1];
  logic signed [W-1:0] vy [S+1];
  logic signed [W-1:0] vz [S+1];
  logic                vt [S+1];
  logic signed [W-1:0] root, dext;

  assign root = W'($signed({1'b0, sres[SQ_STEPS][SQ_STEPS-1:0]}));
  assign dext = W'(sd[SQ_STEPS]);

  always_ff @(posedge clk_i) begin
    if (en[PREP]) begin
      vt[0] <= sclp[SQ_STEPS];
      if (dext < 0) begin
        vx[0] <= root;
        vy[0] <= -dext;
        vz[0] <= HALF_PI_Q;
      end else begin
        vx[0] <= dext;
        vy[0] <= root;
        vz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_vec
    asos_cordic_cell #(.STEP(i), .VECTORING(1'b1), .TAG_W(1)) u_cell (
      .clk_i (clk_i),
      .en_i  (en[VEC0 + i]),
      .x_i   (vx[i]),
      .y_i   (vy[i]),
      .z_i   (vz[i]),
      .tag_i (vt[i]),
      .x_o   (vx[i+1]),
      .y_o   (vy[i+1]),
      .z_o   (vz[i+1]),
      .tag_o (vt[i+1])
    );
  end

  // round to output scaling and saturate
  logic [W:0]       ang_pos, ang_rnd;
  logic [SEP_W-1:0] sep_d, sep_q;
  logic             clamp_q;

  always_comb begin
    ang_pos = vz[S][W-1] ? '0 : {1'b0, vz[S]};
    ang_rnd = (ang_pos + RND) >> SH;
    sep_d   = (ang_rnd > SEP_MAX) ? {SEP_W{1'b1}} : SEP_W'(ang_rnd);
  end

  always_ff @(posedge clk_i) begin
    if (en[FIN]) begin
      sep_q   <= sep_d;
      clamp_q <= vt[S];
    end
  end

  // vx at the end of the chain is the scaled radius and is not needed
  assign rsp_o.valid      = vld_q[N-1];
  assign rsp_o.separation = sep_q;
  assign rsp_o.clamped    = clamp_q & (vx[S][W-1] | ~vx[S][W-1]);
endmodule
